@@ rtl/sia_pkg.sv @@
// Shared constants and types for the signed integer to decimal text block.
package sia_pkg;

    // Bits per decimal digit in packed BCD.
    localparam int unsigned DIGIT_BITS = 4;

    // ASCII codes of the characters that the block emits.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // A BCD digit at or above this value gets the add-three correction.
    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    // Status that the converter reports to the control logic.
    typedef struct packed {
        logic busy;
        logic done;
    } t_dab_stat;

endpackage

@@ rtl/sia_dabble.sv @@
// Bit-serial binary to BCD converter (shift-and-add-three, one bit per cycle).
module sia_dabble #(
    parameter int unsigned VALUE_BITS = 16,
    parameter int unsigned NDIG       = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic [VALUE_BITS-1:0]                 i_mag,
    output sia_pkg::t_dab_stat                    o_stat,
    output logic [NDIG*sia_pkg::DIGIT_BITS-1:0]   o_bcd
);

    localparam int unsigned BCD_BITS = NDIG * sia_pkg::DIGIT_BITS;
    localparam int unsigned CW       = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_BITS-1:0]   r_bcd, n_bcd;
    logic [BCD_BITS-1:0]   w_adj;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    // Add three to every digit that is five or more before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*sia_pkg::DIGIT_BITS +: sia_pkg::DIGIT_BITS] >= sia_pkg::DABBLE_LIMIT) begin
                w_adj[i*sia_pkg::DIGIT_BITS +: sia_pkg::DIGIT_BITS] =
                    r_bcd[i*sia_pkg::DIGIT_BITS +: sia_pkg::DIGIT_BITS] + sia_pkg::DABBLE_ADD;
            end else begin
                w_adj[i*sia_pkg::DIGIT_BITS +: sia_pkg::DIGIT_BITS] =
                    r_bcd[i*sia_pkg::DIGIT_BITS +: sia_pkg::DIGIT_BITS];
            end
        end
    end

    // Load a new magnitude, or shift one binary bit into the BCD register.
    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_load) begin
            n_bin  = i_mag;
            n_bcd  = '0;
            n_cnt  = CW'(VALUE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {w_adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the data registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;

endmodule

@@ rtl/sia_emit.sv @@
// Character emitter: sign, then BCD digits most significant first without leading zeros.
module sia_emit #(
    parameter int unsigned NDIG = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic                                 i_neg,
    input  logic [NDIG*sia_pkg::DIGIT_BITS-1:0]  i_bcd,
    output logic                                 o_busy,
    output logic                                 o_strobe,
    output logic [7:0]                           o_char_code,
    output logic                                 o_last_char
);

    localparam int unsigned BCD_BITS = NDIG * sia_pkg::DIGIT_BITS;
    localparam int unsigned LW       = $clog2(NDIG + 1);

    logic [BCD_BITS-1:0]              r_dig, n_dig;
    logic [LW-1:0]                    r_left, n_left;
    logic                             r_sign, n_sign;
    logic                             r_lead, n_lead;
    logic                             r_busy, n_busy;
    logic                             r_strobe, n_strobe;
    logic [7:0]                       r_char, n_char;
    logic                             r_last, n_last;
    logic [sia_pkg::DIGIT_BITS-1:0]   w_top;

    assign w_top = r_dig[BCD_BITS-1 -: sia_pkg::DIGIT_BITS];

    // One character or one skipped leading zero per cycle.
    always_comb begin
        n_dig    = r_dig;
        n_left   = r_left;
        n_sign   = r_sign;
        n_lead   = r_lead;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        if (i_load) begin
            n_dig  = i_bcd;
            n_left = LW'(NDIG);
            n_sign = i_neg;
            n_lead = 1'b1;
            n_busy = 1'b1;
        end else if (r_busy) begin
            priority if (r_sign) begin
                n_sign   = 1'b0;
                n_strobe = 1'b1;
                n_char   = sia_pkg::CHAR_MINUS;
                n_last   = 1'b0;
            end else if (r_lead && (w_top == '0) && (r_left != LW'(1))) begin
                n_dig  = {r_dig[BCD_BITS-sia_pkg::DIGIT_BITS-1:0], {sia_pkg::DIGIT_BITS{1'b0}}};
                n_left = r_left - 1'b1;
            end else begin
                n_dig    = {r_dig[BCD_BITS-sia_pkg::DIGIT_BITS-1:0], {sia_pkg::DIGIT_BITS{1'b0}}};
                n_left   = r_left - 1'b1;
                n_lead   = 1'b0;
                n_strobe = 1'b1;
                n_char   = sia_pkg::CHAR_ZERO + {4'b0000, w_top};
                n_last   = (r_left == LW'(1));
                if (r_left == LW'(1)) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    // Control state and the strobe are reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_sign   <= 1'b0;
            r_lead   <= 1'b0;
            r_left   <= '0;
        end else begin
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            r_sign   <= n_sign;
            r_lead   <= n_lead;
            r_left   <= n_left;
        end
        r_dig  <= n_dig;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_busy      = r_busy;
    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer to decimal ASCII characters, one word per strobe.
// Conversion runs first in the bit-serial BCD converter, whose done pulse loads the emitter.
// The emitter then gives a minus sign if negative, then the BCD digits without leading zeros.
// busy stays high, and no new item is taken, until the last character is on the output.
// Synchronous active-low reset clears busy and the strobe; results cannot be stalled.
module signed_int_to_decimal_ascii #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  busy,
    output logic                  o_strobe,
    output logic [7:0]            o_char_code,
    output logic                  o_last_char
);

    // Enough decimal digits for any VALUE_BITS-bit magnitude.
    localparam int unsigned NDIG     = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int unsigned BCD_BITS = NDIG * sia_pkg::DIGIT_BITS;

    sia_pkg::t_dab_stat    w_dab;
    logic [BCD_BITS-1:0]   w_bcd;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_accept;
    logic                  w_emit_busy;
    logic                  r_neg;

    assign w_accept = start && !busy;
    assign busy     = w_dab.busy || w_dab.done || w_emit_busy;

    // Magnitude as an unsigned number; the most negative value maps to itself.
    assign w_mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    // Sign of the item in flight.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= i_value[VALUE_BITS-1];
        end
    end

    sia_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_mag   (w_mag),
        .o_stat  (w_dab),
        .o_bcd   (w_bcd)
    );

    sia_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_dab.done),
        .i_neg       (r_neg),
        .i_bcd       (w_bcd),
        .o_busy      (w_emit_busy),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy did not rise after an accepted item");

    // The final character of a run is never followed at once by another.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_char) |=> !o_strobe)
        else $error("character strobe right after the last character");

    // Every word is a digit or a minus sign.
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_char_code == sia_pkg::CHAR_MINUS) ||
                      ((o_char_code >= sia_pkg::CHAR_ZERO) &&
                       (o_char_code <= sia_pkg::CHAR_NINE))))
        else $error("illegal character code");

    // A minus sign is always followed by digits.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_char_code == sia_pkg::CHAR_MINUS)) |-> !o_last_char)
        else $error("minus sign flagged as last character");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_BITS   = 16;
    localparam int RADIX        = 10;
    localparam int RANDOM_WORDS = 280;
    localparam int SETTLE_TICKS = 30;
    localparam int CYCLE_LIMIT  = 200000;

    // One expected character of the decimal text.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char;

    // One directed word: value and its text, right-justified, zero when the
    // text comes from the predictor instead.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [47:0]           text;
    } t_stim;

    localparam int STIM_ROWS = 21;
    localparam t_stim STIM_TABLE [0:STIM_ROWS-1] = '{
        '{16'h0000, "0"},
        '{16'h0001, "1"},
        '{16'hFFFF, "-1"},
        '{16'h0009, "9"},
        '{16'h000A, "10"},
        '{16'hFFF6, "-10"},
        '{16'h0063, "99"},
        '{16'h0064, "100"},
        '{16'hFC19, "-999"},
        '{16'h03E8, "1000"},
        '{16'h270F, "9999"},
        '{16'h2710, "10000"},
        '{16'hD8F0, "-10000"},
        '{16'h7FFF, "32767"},
        '{16'h8000, "-32768"},
        '{16'h8001, "-32767"},
        '{16'h5555, 48'h0},
        '{16'hAAAA, 48'h0},
        '{16'h00FF, 48'h0},
        '{16'hFF00, 48'h0},
        '{16'h04D2, 48'h0}
    };

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  busy;
    logic                  o_strobe;
    logic [7:0]            o_char_code;
    logic                  o_last_char;

    // Text typed in for the word on the inputs, zero for predicted words.
    logic [47:0] word_text = '0;

    t_char chars_due[$];
    int    error_count = 0;
    int    cycle_count = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Predict the characters of one word: sign first, then digits without
    // leading zeros; the most negative value prints its full magnitude.
    function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits [0:5];
        int                    n;
        int                    k;
        mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        n = 0;
        if (v == '0) begin
            chars_due.push_back('{sia_pkg::CHAR_ZERO, 1'b1});
            return;
        end
        if (v[VALUE_BITS-1]) begin
            chars_due.push_back('{sia_pkg::CHAR_MINUS, 1'b0});
        end
        while (mag != '0) begin
            digits[n] = 4'(mag % RADIX);
            mag = VALUE_BITS'(mag / RADIX);
            n++;
        end
        for (k = n - 1; k >= 0; k--) begin
            chars_due.push_back('{sia_pkg::CHAR_ZERO + 8'(digits[k]), k == 0});
        end
    endfunction

    // Queue a typed text; the rightmost byte is the last character.
    function automatic void queue_typed_text(input logic [47:0] txt);
        int b;
        for (b = 5; b >= 0; b--) begin
            if (txt[b*8 +: 8] != 8'h00) begin
                chars_due.push_back('{txt[b*8 +: 8], b == 0});
            end
        end
    endfunction

    // Random word: full range, small and medium magnitudes, decade edges, extremes.
    function automatic logic [VALUE_BITS-1:0] draw_value();
        int kind;
        int mag;
        kind = $urandom_range(0, 9);
        mag = 0;
        case (kind)
            0, 1, 2, 3: return VALUE_BITS'($urandom);
            4, 5:       mag = $urandom_range(0, 99);
            6: begin
                mag = 1;
                repeat ($urandom_range(0, 4)) mag = mag * RADIX;
                mag = mag + $urandom_range(0, 2) - 1;
            end
            7: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'h7FFF;
                    2: return 16'h8000;
                    default: return 16'h8001;
                endcase
            end
            default: mag = $urandom_range(0, 9999);
        endcase
        return $urandom_range(0, 1) ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
    endfunction

    // Offer one word after an idle gap and return at the edge that takes it.
    task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic [47:0] txt,
                             input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_value   <= v;
        word_text <= txt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stop offering words and wait for all outstanding characters.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (chars_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Check each strobed character, then record the word taken at this edge.
    always @(posedge i_clk) begin : char_check
        t_char due;
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                if (chars_due.size() == 0) begin
                    $error("unexpected character: char_code %h, last_char %b",
                           o_char_code, o_last_char);
                    error_count++;
                end else begin
                    due = chars_due.pop_front();
                    if (o_char_code !== due.code) begin
                        $error("char_code: expected %h, actual %h", due.code, o_char_code);
                        error_count++;
                    end
                    if (o_last_char !== due.last) begin
                        $error("last_char: expected %b, actual %b", due.last, o_last_char);
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                if (word_text != '0) begin
                    queue_typed_text(word_text);
                end else begin
                    queue_decimal_text(i_value);
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: directed table first, then random words in bursts and with gaps.
    initial begin : stimulus
        int  i;
        int  gap;
        bit  burst;
        burst = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < STIM_ROWS; i++) begin
            send_word(STIM_TABLE[i].value, STIM_TABLE[i].text, $urandom_range(0, 19));
        end

        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 25 == 0) begin
                burst = (i / 25 == 1) || ($urandom_range(0, 2) == 0);
            end
            // Let the block run dry once in the middle of the random part.
            if (i == RANDOM_WORDS / 2) begin
                wait_drained();
            end
            gap = burst ? 0 : $urandom_range(0, 19);
            send_word(draw_value(), '0, gap);
        end

        wait_drained();
        if (chars_due.size() != 0) begin
            $error("%0d characters never arrived", chars_due.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sia_pkg.sv
rtl/sia_dabble.sv
rtl/sia_emit.sv
rtl/signed_int_to_decimal_ascii.sv
verif/testbench.sv
